[hw/rtl/ece_pkg.sv]
// Shared types, constants and table builder for the easing curve evaluator.
// Used by every module under hw/rtl; depends on nothing else.
package ece_pkg;

    // Curve selector codes, one member per input code.
    typedef enum logic [2:0] {
        CURVE_LINEAR      = 3'd0,
        CURVE_SMOOTH      = 3'd1,
        CURVE_SINE_IN     = 3'd2,
        CURVE_SINE_OUT    = 3'd3,
        CURVE_SINE_INOUT  = 3'd4,
        CURVE_BACK_IN     = 3'd5,
        CURVE_BACK_OUT    = 3'd6,
        CURVE_BACK_INOUT  = 3'd7
    } t_curve;

    // Per-stage load enables, one for each pipeline register stage.
    typedef struct packed {
        logic s6;
        logic s5;
        logic s4;
        logic s3;
        logic s2;
        logic s1;
        logic s0;
    } t_stage_ld;

    localparam int NUM_STAGES = 7;

    // Field widths.
    localparam int CMD_W  = 3;
    localparam int PROG_W = 17;
    localparam int SPAN_W = 24;
    localparam int OUT_W  = 25;

    // Internal widths: curve value, inner back term, product after stage three.
    localparam int U_W    = 17;
    localparam int C_W    = 19;
    localparam int V_W    = 18;
    localparam int Y_W    = 19;
    localparam int B_W    = 36;
    localparam int MAC_W  = 38;
    localparam int PROD_W = 54;
    localparam int SCL_W  = 43;

    // Q16 constants.
    localparam logic [U_W-1:0]          ONE_Q16   = 17'h10000;
    localparam logic [U_W-1:0]          HALF_Q16  = 17'h08000;
    localparam logic signed [C_W-1:0]   C_ONE     = 19'sd65536;
    localparam logic signed [Y_W-1:0]   THREE_Q16 = 19'sd196608;

    // Back overshoot s+1 in Q16 and s in Q32; in-out variant scaled by 1.525.
    localparam logic signed [Y_W-1:0]   Y_IN  = 19'sd177051;
    localparam logic signed [Y_W-1:0]   Y_IO  = 19'sd235596;
    localparam logic signed [B_W-1:0]   Z_IN  = 36'sd111515 <<< 16;
    localparam logic signed [B_W-1:0]   Z_IO  = 36'sd170060 <<< 16;

    // Output saturation limits.
    localparam logic signed [OUT_W-1:0] OUT_MAX = 25'sh0FFFFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 25'sh1000000;

    // Quarter turn in Q30 for the sine table series.
    localparam longint PI_HALF_Q30 = 64'sd1686629713;

    // Quotient of a nonnegative value by a positive divisor, by long division.
    // Only called while the design elaborates.
    function automatic longint quot_pos(input longint num, input longint den);
        longint q;
        longint rem;
        q = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--) begin
            rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
            q = q <<< 1;
            if (rem >= den) begin
                rem = rem - den;
                q = q | 64'sd1;
            end
        end
        return q;
    endfunction

    // One sine table entry in Q16 from a Q30 Taylor series, rounded to nearest.
    // Only called while the design elaborates.
    function automatic logic [U_W-1:0] sine_entry(input int idx, input int tbits);
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint r;
        x = (PI_HALF_Q30 * longint'(idx)) >>> tbits;
        x2 = (x * x) >>> 30;
        term = x;
        sum = x;
        for (int k = 1; k <= 8; k++) begin
            term = (term * x2) >>> 30;
            term = quot_pos(term, longint'((2 * k) * (2 * k + 1)));
            if ((k & 1) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = (sum + 64'sd8192) >>> 14;
        if (r > 64'sd65536) begin
            r = 64'sd65536;
        end
        return U_W'(r);
    endfunction

endpackage

[hw/rtl/ece_sine_rom.sv]
// Quarter-wave sine ROM with two registered read ports (entry and next entry).
// Depends on ece_pkg for the table entry function.
module ece_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [TABLE_BITS:0]         i_addr,
    output logic [ece_pkg::U_W-1:0]     o_lo,
    output logic [ece_pkg::U_W-1:0]     o_hi
);
    import ece_pkg::*;

    localparam int DEPTH = (1 << TABLE_BITS) + 1;
    localparam int AW    = TABLE_BITS + 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    typedef logic [U_W-1:0] t_rom [0:DEPTH-1];

    // Build the table and force it monotone, so neighbor differences stay nonnegative.
    function automatic t_rom rom_init();
        t_rom tab;
        for (int i = 0; i < DEPTH; i++) begin
            tab[i] = sine_entry(i, TABLE_BITS);
        end
        for (int i = 1; i < DEPTH; i++) begin
            if (tab[i] < tab[i-1]) begin
                tab[i] = tab[i-1];
            end
        end
        return tab;
    endfunction

    localparam t_rom SINE_ROM = rom_init();

    logic [AW-1:0]  addr_hi;
    logic [U_W-1:0] r_lo;
    logic [U_W-1:0] r_hi;

    // The upper neighbor stops at the last entry; the fraction is zero there.
    assign addr_hi = (i_addr == LAST) ? LAST : i_addr + AW'(1);

    // Registered reads at both addresses.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= SINE_ROM[i_addr];
            r_hi <= SINE_ROM[addr_hi];
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

[hw/rtl/ece_shape.sv]
// Curve datapath: progress clamp, operand setup, two multiply stages and
// sine interpolation, ending in the Q16 curve value. Depends on ece_pkg, ece_sine_rom.
module ece_shape #(
    parameter int T_FRAC_BITS = 16,
    parameter int TABLE_BITS  = 10
) (
    input  logic                             i_clk,
    input  ece_pkg::t_stage_ld               i_ld,
    input  ece_pkg::t_curve                  i_cmd,
    input  logic [ece_pkg::PROG_W-1:0]       i_progress,
    output logic signed [ece_pkg::C_W-1:0]   o_c
);
    import ece_pkg::*;

    localparam logic [31:0] T_ONE = 32'(1) << T_FRAC_BITS;
    localparam int SHR  = (T_FRAC_BITS >= 16) ? T_FRAC_BITS - 16 : 0;
    localparam int SHL  = (T_FRAC_BITS < 16) ? 16 - T_FRAC_BITS : 0;
    localparam int SH   = 16 - TABLE_BITS;
    localparam int AW   = TABLE_BITS + 1;
    localparam int IP_W = U_W + SH;

    // Stage 0: clamped progress in Q16.
    logic [31:0]    n_t;
    logic [U_W-1:0] n_u;
    t_curve         r0_cmd;
    logic [U_W-1:0] r0_u;

    assign n_t = ({15'b0, i_progress} > T_ONE) ? T_ONE : {15'b0, i_progress};
    assign n_u = U_W'((n_t >> SHR) << SHL);

    always_ff @(posedge i_clk) begin
        if (i_ld.s0) begin
            r0_cmd <= i_cmd;
            r0_u   <= n_u;
        end
    end

    // Stage 1: per-curve operands, square of the back argument, sine angle.
    logic [V_W-1:0]           n_dbl;
    logic [U_W-1:0]           n_m;
    logic                     n_vneg;
    logic signed [V_W-1:0]    n_v;
    logic signed [Y_W-1:0]    n_y;
    logic signed [B_W-1:0]    n_z;
    logic                     n_addone;
    logic                     n_k33;
    logic [U_W-1:0]           n_ang;
    logic                     n_sneg;
    logic [33:0]              n_sq;
    logic [U_W-1:0]           n_aop;

    t_curve                   r1_cmd;
    logic [U_W-1:0]           r1_u;
    logic [U_W-1:0]           r1_aop;
    logic signed [V_W-1:0]    r1_v;
    logic signed [Y_W-1:0]    r1_y;
    logic signed [B_W-1:0]    r1_z;
    logic                     r1_addone;
    logic                     r1_k33;
    logic [AW-1:0]            r1_idx;
    logic [SH-1:0]            r1_frac;
    logic                     r1_sneg;

    assign n_dbl = {r0_u, 1'b0};

    always_comb begin
        n_m      = r0_u;
        n_vneg   = 1'b0;
        n_y      = '0;
        n_z      = '0;
        n_addone = 1'b0;
        n_k33    = 1'b0;
        n_ang    = r0_u;
        n_sneg   = 1'b0;
        unique case (r0_cmd)
            CURVE_LINEAR: begin
                n_m = r0_u;
            end
            CURVE_SMOOTH: begin
                n_y = THREE_Q16 - Y_W'(n_dbl);
            end
            CURVE_SINE_IN: begin
                n_ang = ONE_Q16 - r0_u;
            end
            CURVE_SINE_OUT: begin
                n_ang = r0_u;
            end
            CURVE_SINE_INOUT: begin
                if (r0_u <= HALF_Q16) begin
                    n_ang = U_W'(V_W'(ONE_Q16) - n_dbl);
                end else begin
                    n_ang  = U_W'(n_dbl - V_W'(ONE_Q16));
                    n_sneg = 1'b1;
                end
            end
            CURVE_BACK_IN: begin
                n_y = Y_IN;
                n_z = -Z_IN;
            end
            CURVE_BACK_OUT: begin
                n_m      = ONE_Q16 - r0_u;
                n_vneg   = 1'b1;
                n_y      = Y_IN;
                n_z      = Z_IN;
                n_addone = 1'b1;
            end
            CURVE_BACK_INOUT: begin
                n_y   = Y_IO;
                n_k33 = 1'b1;
                if (r0_u < HALF_Q16) begin
                    n_m = n_dbl[U_W-1:0];
                    n_z = -Z_IO;
                end else begin
                    n_m      = U_W'({ONE_Q16, 1'b0} - n_dbl);
                    n_vneg   = 1'b1;
                    n_z      = Z_IO;
                    n_addone = 1'b1;
                end
            end
        endcase
    end

    assign n_v   = n_vneg ? -$signed({1'b0, n_m}) : $signed({1'b0, n_m});
    assign n_sq  = 34'(n_m) * 34'(n_m);
    assign n_aop = (r0_cmd == CURVE_SMOOTH) ? r0_u : n_sq[32:16];

    always_ff @(posedge i_clk) begin
        if (i_ld.s1) begin
            r1_cmd    <= r0_cmd;
            r1_u      <= r0_u;
            r1_aop    <= n_aop;
            r1_v      <= n_v;
            r1_y      <= n_y;
            r1_z      <= n_z;
            r1_addone <= n_addone;
            r1_k33    <= n_k33;
            r1_idx    <= n_ang[U_W-1:SH];
            r1_frac   <= n_ang[SH-1:0];
            r1_sneg   <= n_sneg;
        end
    end

    // Stage 2: inner term v*y + z, sine table read.
    logic signed [B_W-1:0]    n_b;
    logic [U_W-1:0]           rom_lo;
    logic [U_W-1:0]           rom_hi;

    t_curve                   r2_cmd;
    logic [U_W-1:0]           r2_u;
    logic [U_W-1:0]           r2_aop;
    logic signed [B_W-1:0]    r2_b;
    logic                     r2_addone;
    logic                     r2_k33;
    logic [SH-1:0]            r2_frac;
    logic                     r2_sneg;

    assign n_b = B_W'(MAC_W'(r1_v) * MAC_W'(r1_y) + MAC_W'(r1_z));

    ece_sine_rom #(
        .TABLE_BITS (TABLE_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (i_ld.s2),
        .i_addr (r1_idx),
        .o_lo   (rom_lo),
        .o_hi   (rom_hi)
    );

    always_ff @(posedge i_clk) begin
        if (i_ld.s2) begin
            r2_cmd    <= r1_cmd;
            r2_u      <= r1_u;
            r2_aop    <= r1_aop;
            r2_b      <= n_b;
            r2_addone <= r1_addone;
            r2_k33    <= r1_k33;
            r2_frac   <= r1_frac;
            r2_sneg   <= r1_sneg;
        end
    end

    // Stage 3: full curve product and linear interpolation between table entries.
    logic signed [V_W-1:0]    n_aop_s;
    logic signed [PROD_W-1:0] n_prod;
    logic [U_W-1:0]           n_diff;
    logic [IP_W-1:0]          n_ip;
    logic [U_W-1:0]           n_sin;

    t_curve                   r3_cmd;
    logic [U_W-1:0]           r3_u;
    logic signed [PROD_W-1:0] r3_prod;
    logic [U_W-1:0]           r3_sin;
    logic                     r3_sneg;
    logic                     r3_addone;
    logic                     r3_k33;

    assign n_aop_s = $signed({1'b0, r2_aop});
    assign n_prod  = PROD_W'(n_aop_s) * PROD_W'(r2_b);
    assign n_diff  = rom_hi - rom_lo;
    assign n_ip    = IP_W'(n_diff) * IP_W'(r2_frac);
    assign n_sin   = rom_lo + U_W'(n_ip >> SH);

    always_ff @(posedge i_clk) begin
        if (i_ld.s3) begin
            r3_cmd    <= r2_cmd;
            r3_u      <= r2_u;
            r3_prod   <= n_prod;
            r3_sin    <= n_sin;
            r3_sneg   <= r2_sneg;
            r3_addone <= r2_addone;
            r3_k33    <= r2_k33;
        end
    end

    // Stage 4: floor shifts and the final per-curve selection.
    logic signed [PROD_W-1:0] n_sh32;
    logic signed [PROD_W-1:0] n_sh33;
    logic signed [C_W-1:0]    n_back;
    logic signed [C_W-1:0]    n_sinc;
    logic signed [19:0]       n_cs;
    logic signed [19:0]       n_mid;
    logic signed [C_W-1:0]    n_c;
    logic signed [C_W-1:0]    r4_c;

    assign n_sh32 = r3_prod >>> 32;
    assign n_sh33 = r3_prod >>> 33;
    assign n_back = C_W'(r3_k33 ? n_sh33 : n_sh32) + (r3_addone ? C_ONE : '0);
    assign n_sinc = $signed(C_W'(r3_sin));
    assign n_cs   = r3_sneg ? -$signed(20'(r3_sin)) : $signed(20'(r3_sin));
    assign n_mid  = 20'sd65536 - n_cs;

    always_comb begin
        unique case (r3_cmd)
            CURVE_LINEAR:     n_c = $signed(C_W'(r3_u));
            CURVE_SMOOTH:     n_c = C_W'(n_sh32);
            CURVE_SINE_IN:    n_c = C_ONE - n_sinc;
            CURVE_SINE_OUT:   n_c = n_sinc;
            CURVE_SINE_INOUT: n_c = C_W'(n_mid >>> 1);
            CURVE_BACK_IN:    n_c = n_back;
            CURVE_BACK_OUT:   n_c = n_back;
            CURVE_BACK_INOUT: n_c = n_back;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.s4) begin
            r4_c <= n_c;
        end
    end

    assign o_c = r4_c;

endmodule

[hw/rtl/ece_scale.sv]
// Scaling back end: delays span alongside the curve, multiplies, floors and
// saturates into the output register. Depends on ece_pkg.
module ece_scale (
    input  logic                              i_clk,
    input  ece_pkg::t_stage_ld                i_ld,
    input  logic signed [ece_pkg::SPAN_W-1:0] i_span,
    input  logic signed [ece_pkg::C_W-1:0]    i_c,
    output logic signed [ece_pkg::OUT_W-1:0]  o_eased_value
);
    import ece_pkg::*;

    logic signed [SPAN_W-1:0] r_span [0:4];
    logic signed [SCL_W-1:0]  n_p;
    logic signed [SCL_W-1:0]  r5_p;
    logic signed [SCL_W-1:0]  n_r;
    logic signed [OUT_W-1:0]  n_out;
    logic signed [OUT_W-1:0]  r6_out;

    // Span travels with its item through the curve stages.
    always_ff @(posedge i_clk) begin
        if (i_ld.s0) begin
            r_span[0] <= i_span;
        end
        if (i_ld.s1) begin
            r_span[1] <= r_span[0];
        end
        if (i_ld.s2) begin
            r_span[2] <= r_span[1];
        end
        if (i_ld.s3) begin
            r_span[3] <= r_span[2];
        end
        if (i_ld.s4) begin
            r_span[4] <= r_span[3];
        end
    end

    // Stage 5: span times curve value.
    assign n_p = SCL_W'(r_span[4]) * SCL_W'(i_c);

    always_ff @(posedge i_clk) begin
        if (i_ld.s5) begin
            r5_p <= n_p;
        end
    end

    // Stage 6: floor by 2^16 and clamp to the output range.
    assign n_r = r5_p >>> 16;

    always_comb begin
        priority if (n_r > SCL_W'(OUT_MAX)) begin
            n_out = OUT_MAX;
        end else if (n_r < SCL_W'(OUT_MIN)) begin
            n_out = OUT_MIN;
        end else begin
            n_out = OUT_W'(n_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.s6) begin
            r6_out <= n_out;
        end
    end

    assign o_eased_value = r6_out;

endmodule

[hw/rtl/easing_curve_evaluator.sv]
// Easing curve evaluator: eight easing curves applied to a signed span.
// An accepted word loads stages zero to five in turn, then stage six drives o_valid.
// Throughput: one word per cycle while i_stall is low; set by the seven-stage register
// pipeline, whose widest step is the 18 x 36 bit curve product in stage three.
// Reset clears the stage valid bits only; the sine table is a constant ROM, no clearing pass.
// Stages hold their word under output stall and bubbles collapse as the pipe refills.
module easing_curve_evaluator #(
    parameter int T_FRAC_BITS = 16,
    parameter int TABLE_BITS  = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_cmd,
    input  logic [16:0]        i_progress,
    input  logic signed [23:0] i_span,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [24:0] o_eased_value
);
    import ece_pkg::*;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] rdy;
    t_stage_ld             ld;
    logic signed [C_W-1:0] curve_c;
    logic                  acc;
    logic                  dlv;

    // A stage may load when it is empty or its word moves on this cycle.
    always_comb begin
        rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign ld.s0 = rdy[0];
    assign ld.s1 = rdy[1];
    assign ld.s2 = rdy[2];
    assign ld.s3 = rdy[3];
    assign ld.s4 = rdy[4];
    assign ld.s5 = rdy[5];
    assign ld.s6 = rdy[6];

    // Valid bits follow the data through every loaded stage.
    always_comb begin
        n_vld = r_vld;
        if (rdy[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (rdy[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !rdy[0];
    assign o_valid = r_vld[NUM_STAGES-1];
    assign acc     = i_valid && !o_stall;
    assign dlv     = o_valid && !i_stall;

    // Curve datapath, stages zero to four.
    ece_shape #(
        .T_FRAC_BITS (T_FRAC_BITS),
        .TABLE_BITS  (TABLE_BITS)
    ) u_shape (
        .i_clk      (i_clk),
        .i_ld       (ld),
        .i_cmd      (t_curve'(i_cmd)),
        .i_progress (i_progress),
        .o_c        (curve_c)
    );

    // Span scaling and saturation, stages five and six.
    ece_scale u_scale (
        .i_clk         (i_clk),
        .i_ld          (ld),
        .i_span        (i_span),
        .i_c           (curve_c),
        .o_eased_value (o_eased_value)
    );

    // Occupancy tracks accepted minus delivered words exactly.
    a_occ_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !dlv) |=> ($countones(r_vld) == $past($countones(r_vld)) + 1))
        else $error("pipeline occupancy did not grow on an accepted word");

    a_occ_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!acc && dlv) |=> ($countones(r_vld) + 1 == $past($countones(r_vld))))
        else $error("pipeline occupancy did not shrink on a delivered word");

    a_occ_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc == dlv) |=> ($countones(r_vld) == $past($countones(r_vld))))
        else $error("pipeline occupancy changed without a transfer");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && i_stall) |-> o_stall)
        else $error("input accepted while the full pipeline is stalled");

endmodule
